### design/columnar_conjunctive_predicate_filter_top_assert.svh
// assertion macros for the predicate filter
`ifndef COLUMNAR_CONJUNCTIVE_PREDICATE_FILTER_TOP_ASSERT_SVH
`define COLUMNAR_CONJUNCTIVE_PREDICATE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define CCPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ccpf_pkg.sv
package ccpf_pkg;

    localparam int CHUNK_ROWS  = 2048;
    localparam int MAX_CLAUSES = 4;
    localparam int NUM_VALUES  = 4;
    localparam int ACT_CLAUSES = (MAX_CLAUSES < NUM_VALUES) ? MAX_CLAUSES : NUM_VALUES;

    localparam int CNT_W     = $clog2(CHUNK_ROWS + 1);
    localparam int ROW_IDX_W = 11;
    localparam int SEL_W     = 12;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    typedef enum logic [2:0] {
        OP_LE = 3'd0,
        OP_LT = 3'd1,
        OP_EQ = 3'd2,
        OP_GE = 3'd3,
        OP_GT = 3'd4,
        OP_NE = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CT_DATE  = 2'd0,
        CT_INT4  = 2'd1,
        CT_INT8  = 2'd2,
        CT_UNSUP = 2'd3
    } t_ctype;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_COUNT  = 3'd1,
        REG_OPS    = 3'd2,
        REG_TYPES  = 3'd3,
        REG_CONST0 = 3'd4,
        REG_CONST1 = 3'd5,
        REG_CONST2 = 3'd6,
        REG_CONST3 = 3'd7
    } t_reg;

    typedef struct packed {
        logic                                enabled;
        logic [2:0]                          count;
        logic [11:0]                         ops;
        logic [7:0]                          types;
        logic [NUM_VALUES-1:0][DATA_W-1:0]   constant;
    } t_cfg;

    typedef struct packed {
        logic ok;
        logic unsup;
    } t_clause_res;

    typedef struct packed {
        logic [NUM_VALUES-1:0][DATA_W-1:0] value;
        logic [3:0]                        null_mask;
        logic                              last_row;
    } t_row;

    typedef struct packed {
        logic                 passed;
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_IDX_W-1:0] slot;
        logic [SEL_W-1:0]     selected_count;
        logic                 error;
        logic                 chunk_end;
    } t_result;

endpackage

### design/ccpf_if.sv
interface ccpf_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value_0;
    logic signed [63:0] value_1;
    logic signed [63:0] value_2;
    logic signed [63:0] value_3;
    logic [3:0]         null_mask;
    logic               last_row;

    modport source(output valid, value_0, value_1, value_2, value_3, null_mask, last_row,
                   input ready);
    modport sink(input valid, value_0, value_1, value_2, value_3, null_mask, last_row,
                 output ready);
endinterface

interface ccpf_out_if;
    logic        valid;
    logic        ready;
    logic        passed;
    logic [10:0] row_index;
    logic [10:0] slot;
    logic [11:0] selected_count;
    logic        error;
    logic        chunk_end;

    modport source(output valid, passed, row_index, slot, selected_count, error, chunk_end,
                   input ready);
    modport sink(input valid, passed, row_index, slot, selected_count, error, chunk_end,
                 output ready);
endinterface

### design/columnar_conjunctive_predicate_filter_top.sv
// a row accepted at the input is registered in stage r_s1, then its result word in r_res
//   with r_out_valid, and the word holds while o_out.ready is low
// throughput: one row per cycle unless o_out.ready stalls the output; set by the
//   clause compare stage and its row and selection counters, which update once per row
// reset: i_rst_n is synchronous, active low; clears both pipeline valids,
//   the row and selection counters and all configuration registers
module columnar_conjunctive_predicate_filter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ccpf_in_if.sink                      i_in,
    ccpf_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccpf_pkg::ADDR_W-1:0]  paddr,
    input  logic [ccpf_pkg::DATA_W-1:0]  pwdata,
    output logic [ccpf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import ccpf_pkg::*;

    `include "columnar_conjunctive_predicate_filter_top_assert.svh"

    t_cfg                       cfg;
    logic                       r_s1_valid;
    t_row                       r_s1;
    logic                       r_out_valid;
    t_result                    r_res;
    logic [CNT_W-1:0]           r_row_cnt;
    logic [CNT_W-1:0]           r_sel_cnt;

    t_clause_res [ACT_CLAUSES-1:0] clause_res;
    logic [ACT_CLAUSES-1:0]     active;
    logic                       s1_go;
    logic                       s1_fire;
    logic                       in_fire;
    logic                       overflow;
    logic                       reach;
    logic                       pass;
    logic                       err;
    logic [CNT_W-1:0]           n_row_cnt;
    logic [CNT_W-1:0]           n_sel_cnt;
    t_result                    n_res;

    ccpf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    for (genvar gi = 0; gi < ACT_CLAUSES; gi++) begin : g_clause
        assign active[gi] = 3'(gi) < cfg.count;
        ccpf_clause_cmp u_cmp (
            .i_value (r_s1.value[gi]),
            .i_const (cfg.constant[gi]),
            .i_op    (cfg.ops[3*gi +: 3]),
            .i_ctype (t_ctype'(cfg.types[2*gi +: 2])),
            .i_null  (r_s1.null_mask[gi]),
            .o_res   (clause_res[gi])
        );
    end

    // handshake
    assign s1_go      = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in.valid && i_in.ready;

    // active clauses in order when enabled (else every row passes), first failing one stops the check
    always_comb begin
        reach = 1'b1;
        pass  = 1'b1;
        err   = 1'b0;
        if (cfg.enabled) begin
            for (int i = 0; i < ACT_CLAUSES; i++) begin
                if (active[i] && reach) begin
                    if (clause_res[i].unsup) begin
                        err = 1'b1;
                    end
                    if (!clause_res[i].ok) begin
                        pass  = 1'b0;
                        reach = 1'b0;
                    end
                end
            end
        end
    end

    assign overflow = r_row_cnt >= CNT_W'(CHUNK_ROWS);

    always_comb begin
        n_row_cnt = r_row_cnt;
        n_sel_cnt = r_sel_cnt;
        n_res.chunk_end = r_s1.last_row;
        n_res.slot      = '0;
        if (overflow) begin
            n_res.passed    = 1'b0;
            n_res.error     = 1'b1;
            n_res.row_index = ROW_IDX_W'(CHUNK_ROWS - 1);
        end else begin
            n_res.passed    = pass;
            n_res.error     = err;
            n_res.row_index = ROW_IDX_W'(r_row_cnt);
            n_row_cnt       = r_row_cnt + 1'b1;
            if (pass) begin
                n_res.slot = ROW_IDX_W'(r_sel_cnt);
                n_sel_cnt  = r_sel_cnt + 1'b1;
            end
        end
        n_res.selected_count = SEL_W'(n_sel_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_cnt   <= '0;
            r_sel_cnt   <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_go) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                if (r_s1.last_row) begin
                    r_row_cnt <= '0;
                    r_sel_cnt <= '0;
                end else begin
                    r_row_cnt <= n_row_cnt;
                    r_sel_cnt <= n_sel_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.value[0]  <= i_in.value_0;
            r_s1.value[1]  <= i_in.value_1;
            r_s1.value[2]  <= i_in.value_2;
            r_s1.value[3]  <= i_in.value_3;
            r_s1.null_mask <= i_in.null_mask;
            r_s1.last_row  <= i_in.last_row;
        end
        if (s1_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.passed         = r_res.passed;
    assign o_out.row_index      = r_res.row_index;
    assign o_out.slot           = r_res.slot;
    assign o_out.selected_count = r_res.selected_count;
    assign o_out.error          = r_res.error;
    assign o_out.chunk_end      = r_res.chunk_end;

    `CCPF_ASSERT_NOW(a_pass_no_err, i_clk, i_rst_n, o_out.valid && o_out.passed, !o_out.error, "selected word flagged as error")
    `CCPF_ASSERT_NOW(a_slot_count, i_clk, i_rst_n, o_out.valid && o_out.passed, (SEL_W'(o_out.slot) + 1'b1) == o_out.selected_count, "slot and selected count disagree")
    `CCPF_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, o_out.valid && !o_out.passed, o_out.slot == '0, "slot set on rejected row")
    `CCPF_ASSERT_NEXT(a_chunk_clear, i_clk, i_rst_n, s1_fire && r_s1.last_row, (r_row_cnt == '0) && (r_sel_cnt == '0), "counters not cleared after last row")

endmodule

### design/ccpf_cfg_regs.sv
module ccpf_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccpf_pkg::ADDR_W-1:0]  paddr,
    input  logic [ccpf_pkg::DATA_W-1:0]  pwdata,
    output logic [ccpf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ccpf_pkg::t_cfg               o_cfg
);
    import ccpf_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_ENABLE: r_cfg.enabled     <= pwdata[0];
                REG_COUNT:  r_cfg.count       <= pwdata[2:0];
                REG_OPS:    r_cfg.ops         <= pwdata[11:0];
                REG_TYPES:  r_cfg.types       <= pwdata[7:0];
                REG_CONST0: r_cfg.constant[0] <= pwdata;
                REG_CONST1: r_cfg.constant[1] <= pwdata;
                REG_CONST2: r_cfg.constant[2] <= pwdata;
                REG_CONST3: r_cfg.constant[3] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_cfg.enabled};
            REG_COUNT:  prdata = {{(DATA_W-3){1'b0}}, r_cfg.count};
            REG_OPS:    prdata = {{(DATA_W-12){1'b0}}, r_cfg.ops};
            REG_TYPES:  prdata = {{(DATA_W-8){1'b0}}, r_cfg.types};
            REG_CONST0: prdata = r_cfg.constant[0];
            REG_CONST1: prdata = r_cfg.constant[1];
            REG_CONST2: prdata = r_cfg.constant[2];
            REG_CONST3: prdata = r_cfg.constant[3];
        endcase
    end

endmodule

### design/ccpf_clause_cmp.sv
module ccpf_clause_cmp (
    input  logic [63:0]           i_value,
    input  logic [63:0]           i_const,
    input  logic [2:0]            i_op,
    input  ccpf_pkg::t_ctype      i_ctype,
    input  logic                  i_null,
    output ccpf_pkg::t_clause_res o_res
);
    import ccpf_pkg::*;

    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               lt;
    logic               eq;
    logic               cmp;

    always_comb begin
        if (i_ctype == CT_INT8) begin
            a = i_value;
            b = i_const;
        end else begin
            // date and int4 use the low word, signed
            a = {{32{i_value[31]}}, i_value[31:0]};
            b = {{32{i_const[31]}}, i_const[31:0]};
        end
        lt = a < b;
        eq = a == b;
        unique case (i_op)
            OP_LE:   cmp = lt | eq;
            OP_LT:   cmp = lt;
            OP_EQ:   cmp = eq;
            OP_GE:   cmp = !lt;
            OP_GT:   cmp = !lt & !eq;
            OP_NE:   cmp = !eq;
            default: cmp = 1'b0;
        endcase
        o_res.unsup = !i_null && (i_ctype == CT_UNSUP);
        o_res.ok    = !i_null && (i_ctype != CT_UNSUP) && cmp;
    end

endmodule
